// ----- rtl/core/hgcmap_pkg.sv -----
// ============================================================================
// hgcmap_pkg: shared types and constants of the height gradient colormap
// Color stop table, water color and configuration register indexes.
// ============================================================================
package hgcmap_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int NUM_STOPS    = 5;

   // quotient bits of the per-channel interpolation divider (step <= 255)
   localparam int LERP_STEPS   = 8;

   // channel order: 0 red, 1 green, 2 blue
   typedef logic [0:NUM_CHANNELS-1][7:0] rgb_type;

   localparam rgb_type STOP_COLOR [NUM_STOPS] = '{
      '{8'd0,   8'd102, 8'd0},
      '{8'd154, 8'd205, 8'd50},
      '{8'd251, 8'd236, 8'd93},
      '{8'd212, 8'd175, 8'd55},
      '{8'd166, 8'd60,  8'd20}
   };

   localparam rgb_type WATER_COLOR = '{8'd0, 8'd49, 8'd83};

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWEST  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGHEST = 2'd1;

endpackage

// ----- rtl/core/height_gradient_colormap_top.sv -----
// ============================================================================
// height_gradient_colormap_top: terrain height to RGB pixel
// Normalizes a height sample into a fraction and interpolates between five
// color stops; flooded samples get the water color.
// ============================================================================
// One sample per clock while req_ready is high. Each transaction accepted
// on req_ passes the input subtract, the normalizing divider, one quotient
// bit per stage, the alpha stage, the stop select, one multiply stage and an
// eight stage divider per color channel before it reaches rsp_. A two entry
// output queue lets the pipeline keep accepting while a result waits;
// req_ready drops only when both entries are full. csr_ is always ready;
// write it only while idle.
module height_gradient_colormap_top #(
   parameter int HEIGHT_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [HEIGHT_BITS-1:0]                  req_height,
   input  logic                                    req_underwater,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [7:0]                              rsp_red,
   output logic [7:0]                              rsp_green,
   output logic [7:0]                              rsp_blue,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [hgcmap_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [HEIGHT_BITS-1:0]                  csr_data
);

   localparam int H  = HEIGHT_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int AW = F + 1;
   localparam int LS = hgcmap_pkg::LERP_STEPS;
   localparam int PW = AW + LS;
   localparam int NC = hgcmap_pkg::NUM_CHANNELS;

   localparam longint FONE = longint'(1) << F;
   localparam longint T1   = (FONE + 5) / 10;
   localparam longint T2   = FONE / 4;
   localparam longint T3   = (FONE * 2 + 2) / 5;
   localparam longint T4   = (FONE * 101 + 50) / 100;

   localparam logic [AW-1:0] THR [4] = '{AW'(0), AW'(T1), AW'(T2), AW'(T3)};
   localparam logic [AW-1:0] DEN [4] = '{AW'(T1), AW'(T2 - T1), AW'(T3 - T2),
                                         AW'(T4 - T3)};

   // stage map
   localparam int NS       = F + 4 + LS + 1;

   // ---------------------------------------------------------------- config
   logic [H-1:0] lowest_ff;
   logic [H-1:0] highest_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= '0;
         highest_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            hgcmap_pkg::CSR_LOWEST:  lowest_ff  <= csr_data;
            hgcmap_pkg::CSR_HIGHEST: highest_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   logic [NS-1:0] v_ff;
   logic [1:0]    count_ff;
   logic          en;
   logic          push;
   logic          pop;

   assign en        = (count_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && v_ff[NS-1];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end

   // ------------------------------------------------------- input / subtract
   logic [H:0] in_diff_ff;
   logic [H:0] in_range_ff;
   logic       in_uw_ff;
   logic [H:0] diff_in;
   logic [H:0] range_in;

   assign diff_in  = {req_height[H-1], req_height} - {lowest_ff[H-1], lowest_ff};
   assign range_in = {highest_ff[H-1], highest_ff} - {lowest_ff[H-1], lowest_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         in_diff_ff  <= diff_in;
         in_range_ff <= range_in;
         in_uw_ff    <= req_underwater;
      end
   end

   // ------------------------------------------------- normalizing divider
   logic [H-1:0] dv_rem_ff   [0:F];
   logic [H-1:0] dv_range_ff [0:F];
   logic [F-1:0] dv_quot_ff  [0:F];
   logic [F:0]   dv_zero_ff;
   logic [F:0]   dv_sat_ff;
   logic [F:0]   dv_uw_ff;
   logic         zero_in;
   logic         sat_in;

   // height at or below lowest, or an empty range, gives fraction zero
   assign zero_in = in_range_ff[H] || (in_range_ff == '0) ||
                    in_diff_ff[H] || (in_diff_ff == '0);
   assign sat_in  = $signed(in_diff_ff) >= $signed(in_range_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]   <= in_diff_ff[H-1:0];
         dv_range_ff[0] <= in_range_ff[H-1:0];
         dv_quot_ff[0]  <= '0;
         dv_zero_ff[0]  <= zero_in;
         dv_sat_ff[0]   <= sat_in;
         dv_uw_ff[0]    <= in_uw_ff;
      end
   end

   for (genvar j = 1; j <= F; j++) begin : g_dv
      logic [H:0]   twice;
      logic         take;
      logic [H-1:0] rem_in;
      logic [F-1:0] quot_in;

      always_comb begin
         twice   = {dv_rem_ff[j-1], 1'b0};
         take    = twice >= {1'b0, dv_range_ff[j-1]};
         rem_in  = take ? H'(twice - {1'b0, dv_range_ff[j-1]}) : twice[H-1:0];
         quot_in = {dv_quot_ff[j-1][F-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j]   <= rem_in;
            dv_range_ff[j] <= dv_range_ff[j-1];
            dv_quot_ff[j]  <= quot_in;
            dv_zero_ff[j]  <= dv_zero_ff[j-1];
            dv_sat_ff[j]   <= dv_sat_ff[j-1];
            dv_uw_ff[j]    <= dv_uw_ff[j-1];
         end
      end
   end

   // ------------------------------------------------------------------ alpha
   logic [AW-1:0] al_alpha_ff;
   logic          al_uw_ff;
   logic [AW-1:0] alpha_in;

   assign alpha_in = dv_zero_ff[F] ? '0 :
                     dv_sat_ff[F]  ? AW'(FONE) : {1'b0, dv_quot_ff[F]};

   always_ff @(posedge clock) begin
      if (en) begin
         al_alpha_ff <= alpha_in;
         al_uw_ff    <= dv_uw_ff[F];
      end
   end

   // ----------------------------------------------------------- stop select
   logic [1:0]    sg_seg_ff;
   logic [AW-1:0] sg_num_ff;
   logic          sg_uw_ff;
   logic [1:0]    seg_in;
   logic [AW-1:0] num_in;

   always_comb begin
      if (al_alpha_ff <= THR[1]) begin
         seg_in = 2'd0;
      end else if (al_alpha_ff <= THR[2]) begin
         seg_in = 2'd1;
      end else if (al_alpha_ff <= THR[3]) begin
         seg_in = 2'd2;
      end else begin
         seg_in = 2'd3;
      end
      num_in = al_alpha_ff - THR[seg_in];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sg_seg_ff <= seg_in;
         sg_num_ff <= num_in;
         sg_uw_ff  <= al_uw_ff;
      end
   end

   // ------------------------------------------- multiply and channel divider
   logic [PW-1:0]            ld_rem_ff  [0:LS][0:NC-1];
   logic [LS-1:0]            ld_quot_ff [0:LS][0:NC-1];
   hgcmap_pkg::rgb_type      ld_from_ff [0:LS];
   logic [NC-1:0]            ld_down_ff [0:LS];
   logic [AW-1:0]            ld_den_ff  [0:LS];
   logic [LS:0]              ld_uw_ff;
   hgcmap_pkg::rgb_type      from_in;
   hgcmap_pkg::rgb_type      to_in;

   assign from_in = hgcmap_pkg::STOP_COLOR[{1'b0, sg_seg_ff}];
   assign to_in   = hgcmap_pkg::STOP_COLOR[{1'b0, sg_seg_ff} + 3'd1];

   always_ff @(posedge clock) begin
      if (en) begin
         ld_from_ff[0] <= from_in;
         ld_den_ff[0]  <= DEN[sg_seg_ff];
         ld_uw_ff[0]   <= sg_uw_ff;
      end
   end

   for (genvar c = 0; c < NC; c++) begin : g_mul
      logic          down_in;
      logic [7:0]    delta_in;
      logic [PW-1:0] prod_in;

      always_comb begin
         down_in  = to_in[c] < from_in[c];
         delta_in = down_in ? from_in[c] - to_in[c] : to_in[c] - from_in[c];
         prod_in  = PW'(delta_in) * PW'(sg_num_ff);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ld_rem_ff[0][c]  <= prod_in;
            ld_quot_ff[0][c] <= '0;
            ld_down_ff[0][c] <= down_in;
         end
      end
   end

   for (genvar j = 1; j <= LS; j++) begin : g_ld
      logic [PW-1:0] shifted;

      assign shifted = PW'(ld_den_ff[j-1]) << (LS - j);

      always_ff @(posedge clock) begin
         if (en) begin
            ld_from_ff[j] <= ld_from_ff[j-1];
            ld_down_ff[j] <= ld_down_ff[j-1];
            ld_den_ff[j]  <= ld_den_ff[j-1];
            ld_uw_ff[j]   <= ld_uw_ff[j-1];
         end
      end

      for (genvar c = 0; c < NC; c++) begin : g_ch
         logic          take;
         logic [PW-1:0] rem_in;
         logic [LS-1:0] quot_in;

         always_comb begin
            take    = ld_rem_ff[j-1][c] >= shifted;
            rem_in  = take ? ld_rem_ff[j-1][c] - shifted : ld_rem_ff[j-1][c];
            quot_in = {ld_quot_ff[j-1][c][LS-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               ld_rem_ff[j][c]  <= rem_in;
               ld_quot_ff[j][c] <= quot_in;
            end
         end
      end
   end

   // ------------------------------------------------------------ final color
   hgcmap_pkg::rgb_type lerp_color;
   hgcmap_pkg::rgb_type out_color;
   logic [NC-1:0]       ch_ovf;
   logic                lerp_ovf;

   for (genvar c = 0; c < NC; c++) begin : g_fin
      logic [7:0] step;

      // falling channels round the step up so the value truncates toward zero
      always_comb begin
         step = ld_quot_ff[LS][c] +
                8'(ld_down_ff[LS][c] && (ld_rem_ff[LS][c] != '0));
         lerp_color[c] = ld_down_ff[LS][c] ? ld_from_ff[LS][c] - step
                                           : ld_from_ff[LS][c] + step;
         ch_ovf[c] = ld_down_ff[LS][c] ? (step > ld_from_ff[LS][c])
                     : ({1'b0, ld_from_ff[LS][c]} + {1'b0, step} > 9'd255);
      end
   end

   assign lerp_ovf  = |ch_ovf;
   assign out_color = ld_uw_ff[LS] ? hgcmap_pkg::WATER_COLOR : lerp_color;

   // ----------------------------------------------------------- output queue
   hgcmap_pkg::rgb_type buf_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= out_color;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_red   = buf_ff[rd_ptr_ff][0];
   assign rsp_green = buf_ff[rd_ptr_ff][1];
   assign rsp_blue  = buf_ff[rd_ptr_ff][2];

   // ------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("result pushed into a full output queue");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

   a_lerp_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-1] && !ld_uw_ff[LS]) |-> !lerp_ovf)
      else $error("interpolated channel left the stop range");

endmodule

// ----- bench/height_gradient_colormap_top_test.sv -----
// ============================================================================
// height_gradient_colormap_top_test: self-checking bench for the colormap
// Streams height samples through the block under several register settings
// and checks each pixel against a local computation of the color ramp.
// ============================================================================
module height_gradient_colormap_top_test;

   localparam int HEIGHT_W        = 16;
   localparam int FRAC_W          = 16;
   localparam longint FRAC_ONE    = longint'(1) << FRAC_W;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PER_SET  = 211;
   localparam int NUM_SETS        = 9;

   // indexes that decode to no register; writes there must be dropped
   localparam logic [hgcmap_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [hgcmap_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   localparam int STOP_RGB [5][3] = '{
      '{0,   102, 0},
      '{154, 205, 50},
      '{251, 236, 93},
      '{212, 175, 55},
      '{166, 60,  20}
   };
   localparam int FLOOD_RGB [3] = '{0, 49, 83};

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                underwater;
   } sample_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [HEIGHT_W-1:0]       req_height = '0;
   logic                      req_underwater = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_red;
   logic [7:0]                rsp_green;
   logic [7:0]                rsp_blue;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [hgcmap_pkg::CSR_INDEX_BITS-1:0] csr_index = hgcmap_pkg::CSR_LOWEST;
   logic [HEIGHT_W-1:0]       csr_data = '0;

   // local copy of the two height registers
   logic [HEIGHT_W-1:0]       cfg_lowest = '0;
   logic [HEIGHT_W-1:0]       cfg_highest = '0;

   sample_type pending_samples[$];
   pixel_type  expected_pixels[$];

   int  sender_idle_pct = 35;
   int  receiver_idle_pct = 75;
   bit  hold_off_req = 1'b0;
   bit  hold_off_started = 1'b0;
   int  hold_left = 0;
   int  mismatch_count = 0;
   bit  leftover = 1'b0;
   int  quiet_cycles = 0;

   height_gradient_colormap_top #(
      .HEIGHT_BITS   (HEIGHT_W),
      .FRACTION_BITS (FRAC_W)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_height     (req_height),
      .req_underwater (req_underwater),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // color ramp
   // ---------------------------------------------------------------------
   function automatic longint stop_level(int seg);
      case (seg)
         0:       return 0;
         1:       return (FRAC_ONE + 5) / 10;
         2:       return FRAC_ONE / 4;
         3:       return (FRAC_ONE * 2 + 2) / 5;
         default: return (FRAC_ONE * 101 + 50) / 100;
      endcase
   endfunction

   function automatic pixel_type color_for_sample(sample_type s,
                                                  logic [HEIGHT_W-1:0] lowest,
                                                  logic [HEIGHT_W-1:0] highest);
      longint h;
      longint lo;
      longint hi;
      longint alpha;
      longint num;
      longint den;
      int     seg;
      int     from;
      int     to;
      int     chan [3];
      h     = longint'($signed(s.height));
      lo    = longint'($signed(lowest));
      hi    = longint'($signed(highest));
      alpha = 0;
      if (s.underwater) begin
         return pixel_type'{FLOOD_RGB[0][7:0], FLOOD_RGB[1][7:0], FLOOD_RGB[2][7:0]};
      end
      // empty range or a height at or below the floor leaves the fraction at zero
      if (hi > lo && h > lo) begin
         alpha = ((h - lo) << FRAC_W) / (hi - lo);
         if (alpha > FRAC_ONE) alpha = FRAC_ONE;
      end
      seg = 1;
      while (seg < 4 && alpha > stop_level(seg)) seg++;
      num = alpha - stop_level(seg - 1);
      den = stop_level(seg) - stop_level(seg - 1);
      for (int c = 0; c < 3; c++) begin
         from = STOP_RGB[seg-1][c];
         to   = STOP_RGB[seg][c];
         // falling channels round the step up so the value truncates toward zero
         if (to >= from) chan[c] = from + int'((longint'(to - from) * num) / den);
         else            chan[c] = from - int'((longint'(from - to) * num + den - 1) / den);
      end
      return pixel_type'{chan[0][7:0], chan[1][7:0], chan[2][7:0]};
   endfunction

   // ---------------------------------------------------------------------
   // sample driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels = {expected_pixels,
                               color_for_sample({req_height, req_underwater},
                                                cfg_lowest, cfg_highest)};
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_sample    = pending_samples.pop_front();
               req_valid      <= 1'b1;
               req_height     <= next_sample.height;
               req_underwater <= next_sample.underwater;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // pixel monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : pixel_monitor
      pixel_type want;
      pixel_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_red, rsp_green, rsp_blue};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                        got.red, got.green, got.blue);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  $display({"%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, ",
                            "actual r=%0d g=%0d b=%0d"},
                           $time, want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
                  mismatch_count++;
               end
            end
         end
         if (hold_off_req && !hold_off_started) begin
            hold_off_started = 1'b1;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles without any transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic write_register(logic [hgcmap_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [HEIGHT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == hgcmap_pkg::CSR_LOWEST)       cfg_lowest  <= value;
      else if (index == hgcmap_pkg::CSR_HIGHEST) cfg_highest <= value;
   endtask

   task automatic queue_sample(int height, bit underwater);
      pending_samples = {pending_samples,
                         sample_type'{height[HEIGHT_W-1:0], underwater}};
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_height(int lo, int hi);
      int pick;
      int mark;
      pick = $urandom_range(99);
      if (lo < hi && pick < 60) return lo + int'($urandom_range(hi - lo));
      if (lo < hi && pick < 75) begin
         // land near one of the interior stop thresholds
         case ($urandom_range(2))
            0:       mark = 100;
            1:       mark = 250;
            default: mark = 400;
         endcase
         return lo + (hi - lo) * mark / 1000 + int'($urandom_range(4)) - 2;
      end
      if (pick < 85) return (pick[0] ? lo : hi) + int'($urandom_range(4)) - 2;
      return int'($urandom_range(16'hFFFF));
   endfunction

   initial begin : stimulus
      int lo_set [NUM_SETS] = '{-1000, -32768, 0, 500, 100, 32767, 0, 0, 0};
      int hi_set [NUM_SETS] = '{1000, 32767, 0, -500, 101, -32768, 0, 0, 0};
      int edge_heights [15] = '{-32768, 32767, -1000, 1000, -1001, 1001, -999, 999,
                                -800, -799, -500, -499, -200, -199, 0};
      int a;
      int b;
      int lo;
      int hi;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset value: empty range
      queue_sample(0, 1'b0);
      queue_sample(1, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(32767, 1'b0);
      queue_sample(-32768, 1'b0);
      wait_idle();

      for (int set = 0; set < NUM_SETS; set++) begin
         case (set / 3)
            0: begin
               sender_idle_pct   = 35;
               receiver_idle_pct = 75;
            end
            1: begin
               sender_idle_pct   = 75;
               receiver_idle_pct = 35;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         a = int'($signed(16'($urandom_range(16'hFFFF))));
         b = int'($signed(16'($urandom_range(16'hFFFF))));
         lo = lo_set[set];
         hi = hi_set[set];
         if (set == 6) begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end else if (set == 7) begin
            lo = a;
            hi = b;
         end else if (set == 8) begin
            lo = int'($urandom_range(64768)) - 32768;
            hi = lo + int'($urandom_range(700, 1));
         end

         write_register(hgcmap_pkg::CSR_LOWEST, lo[HEIGHT_W-1:0]);
         write_register(hgcmap_pkg::CSR_HIGHEST, hi[HEIGHT_W-1:0]);
         write_register(set[0] ? CSR_SPARE_A : CSR_SPARE_B, 16'($urandom_range(16'hFFFF)));

         if (set == 0) begin
            foreach (edge_heights[k]) queue_sample(edge_heights[k], 1'b0);
            queue_sample(-32768, 1'b1);
            queue_sample(32767, 1'b1);
            queue_sample(0, 1'b1);
            queue_sample(-800, 1'b1);
         end
         // back-pressure burst while the sender streams without gaps
         if (set == 6) hold_off_req = 1'b1;

         for (int n = 0; n < RANDOM_PER_SET; n++)
            queue_sample(pick_height(lo, hi), $urandom_range(99) < 20);
         wait_idle();
      end

      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
         leftover = 1'b1;
      end
      if (mismatch_count == 0 && !leftover) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
